>>> rtl/plc_pkg.sv
package plc_pkg;

	// Field widths fixed by the stream payload
	localparam int SAMPLE_W = 12;
	localparam int INDEX_W  = 3;
	localparam int MV_W     = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 4;

	// Number of factory calibration points
	localparam int DFLT_POINTS = 8;

	// Beat kinds on the input tuser bit
	localparam logic CMD_CONVERT = 1'b0;
	localparam logic CMD_WRITE   = 1'b1;

	// Status codes on the output tuser field
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNCAL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SEG = 2'd2;

	// Divider control and status between the sequencer and the serial divider
	typedef struct packed {
		logic start;
	} plc_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} plc_div_sts_t;

	// Factory raw codes; entries past the defaults clear to zero
	function automatic logic [SAMPLE_W-1:0] dflt_raw(input int i);
		logic [SAMPLE_W-1:0] v;
		case (i)
			0:       v = 12'd2182;
			1:       v = 12'd2396;
			2:       v = 12'd2525;
			3:       v = 12'd2625;
			4:       v = 12'd2748;
			5:       v = 12'd2841;
			6:       v = 12'd3055;
			7:       v = 12'd3283;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Factory voltages in millivolts
	function automatic logic [MV_W-1:0] dflt_mv(input int i);
		logic [MV_W-1:0] v;
		case (i)
			0:       v = 16'd10000;
			1:       v = 16'd11000;
			2:       v = 16'd11500;
			3:       v = 16'd12000;
			4:       v = 16'd12500;
			5:       v = 16'd13000;
			6:       v = 16'd14000;
			7:       v = 16'd15000;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/plc_div.sv
// Restoring serial divider: one quotient bit per cycle.
// The caller guarantees the quotient fits in MV_W bits (num < den << MV_W).
module plc_div #(
	parameter int DEN_W = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  plc_pkg::plc_div_ctl_t      ctl,
	input  logic [DEN_W+plc_pkg::MV_W-1:0] num,
	input  logic [DEN_W-1:0]           den,
	output plc_pkg::plc_div_sts_t      sts,
	output logic [plc_pkg::MV_W-1:0]   quot
);

	localparam int QW    = plc_pkg::MV_W;
	localparam int CNT_W = $clog2(QW + 1);

	logic [DEN_W-1:0] rem_q;
	logic [QW-1:0]    quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic [DEN_W:0]   part;
	logic [DEN_W+1:0] diff;
	logic             ge;

	// Shared subtractor: trial subtract of the divisor from the partial remainder
	assign part = {rem_q, quo_q[QW-1]};
	assign diff = {1'b0, part} - {2'b00, den_q};
	assign ge   = ~diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q <= CNT_W'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= num[DEN_W+QW-1:QW];
			quo_q <= num[QW-1:0];
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign quot     = quo_q;

endmodule

>>> rtl/piecewise_linear_adc_calibration.sv
// Channel   | Direction | Beat contents
// s_axis    | in        | tuser: cmd; tdata: sample, point_index, point_raw, point_millivolts
// m_axis    | out       | tuser: status; tdata: millivolts
// cfg       | in        | cfg_wdata: point_count, written when cfg_wen is high
//
// A point write gives no beat out. A sample is either flagged uncalibrated,
// clamped at the first or last point, or interpolated: the table is scanned
// one entry a cycle through a single read mux, and the divide runs 16 steps in plc_div.
// Reset (arst_n low) loads the factory table and sets point_count to 8.
// A finished result waits in the output register while the next beat is taken;
// a new result stalls only while that register is full and m_axis_tready is low.
module piecewise_linear_adc_calibration #(
	parameter int TABLE_POINTS = 8,
	parameter int ADC_BITS     = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [11:0] sample, [14:12] point_index,
	                                   // [26:15] point_raw, [42:27] point_millivolts,
	                                   // [47:43] zero
	input  logic        s_axis_tuser,  // [0] cmd
	// Master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] millivolts
	output logic [1:0]  m_axis_tuser,  // [1:0] status
	// Configuration
	input  logic        cfg_wen,
	input  logic [3:0]  cfg_wdata      // [3:0] point_count
);

	localparam int MV_W  = plc_pkg::MV_W;
	localparam int RAW_W = (ADC_BITS < plc_pkg::SAMPLE_W) ? ADC_BITS : plc_pkg::SAMPLE_W;
	localparam int IW    = $clog2(TABLE_POINTS);
	localparam int CW    = $clog2(TABLE_POINTS + 1);
	localparam int PW    = RAW_W + MV_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_FIRST,
		S_RD_LAST,
		S_SCAN,
		S_MUL,
		S_DIV_START,
		S_DIV_WAIT,
		S_FINISH
	} state_t;

	// Unpack the input beat
	logic                       in_cmd;
	logic [plc_pkg::SAMPLE_W-1:0] in_sample;
	logic [plc_pkg::INDEX_W-1:0]  in_index;
	logic [plc_pkg::SAMPLE_W-1:0] in_raw;
	logic [MV_W-1:0]            in_mv;

	assign in_cmd    = s_axis_tuser;
	assign in_sample = s_axis_tdata[11:0];
	assign in_index  = s_axis_tdata[14:12];
	assign in_raw    = s_axis_tdata[26:15];
	assign in_mv     = s_axis_tdata[42:27];

	// Calibration table, point count and sequencer state
	logic [RAW_W-1:0]         raw_q [TABLE_POINTS];
	logic [MV_W-1:0]          mv_q  [TABLE_POINTS];
	logic [plc_pkg::COUNT_W-1:0] point_count_q;

	state_t                   state_q;
	logic [RAW_W-1:0]         x_q;
	logic [CW-1:0]            n_q;
	logic [IW-1:0]            rd_idx_q;
	logic [RAW_W-1:0]         x0_q, x1_q;
	logic [MV_W-1:0]          y0_q, y1_q;
	logic [PW-1:0]            prod_q;
	logic [RAW_W-1:0]         den_q;
	logic                     neg_q;
	logic [MV_W-1:0]          res_mv_q;
	logic [plc_pkg::STATUS_W-1:0] res_st_q;
	logic                     m_valid_q;
	logic [MV_W-1:0]          m_mv_q;
	logic [plc_pkg::STATUS_W-1:0] m_st_q;

	logic                     in_fire;
	logic [CW-1:0]            n_sat;
	logic [IW-1:0]            last_idx;
	logic [RAW_W-1:0]         rd_raw;
	logic [MV_W-1:0]          rd_mv;
	logic                     x_lt_rd;
	logic                     rd_lt_x;
	logic [RAW_W-1:0]         dx, dseg;
	logic [MV_W:0]            dy;
	logic                     dy_neg;
	logic [MV_W-1:0]          dy_mag;
	logic signed [MV_W+1:0]   sum;

	plc_pkg::plc_div_ctl_t    div_ctl;
	plc_pkg::plc_div_sts_t    div_sts;
	logic [MV_W-1:0]          div_quot;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// Saturate point_count to the table depth
	assign n_sat    = (32'(point_count_q) > TABLE_POINTS) ? CW'(TABLE_POINTS)
	                                                      : CW'(point_count_q);
	assign last_idx = IW'(n_q - 1'b1);

	// Single read port on the table, and one comparator pair against the sample
	assign rd_raw  = raw_q[rd_idx_q];
	assign rd_mv   = mv_q[rd_idx_q];
	assign x_lt_rd = (x_q < rd_raw);
	assign rd_lt_x = (rd_raw < x_q);

	// Segment deltas; the scan leaves x0 <= x < x1
	assign dx     = x_q - x0_q;
	assign dseg   = x1_q - x0_q;
	assign dy     = {1'b0, y1_q} - {1'b0, y0_q};
	assign dy_neg = dy[MV_W];
	assign dy_mag = dy_neg ? MV_W'(-dy) : dy[MV_W-1:0];

	// Apply the truncated step to the lower point's voltage
	assign sum = neg_q ? ($signed({2'b00, y0_q}) - $signed({2'b00, div_quot}))
	                   : ($signed({2'b00, y0_q}) + $signed({2'b00, div_quot}));

	assign div_ctl.start = (state_q == S_DIV_START);

	plc_div #(
		.DEN_W (RAW_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (prod_q),
		.den    (den_q),
		.sts    (div_sts),
		.quot   (div_quot)
	);

	// Point count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= plc_pkg::COUNT_W'(plc_pkg::DFLT_POINTS);
		end else if (cfg_wen) begin
			point_count_q <= cfg_wdata;
		end
	end

	// Calibration table: load factory points on reset, store one point per write beat.
	// Indices past the table fall through without a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < TABLE_POINTS; e++) begin
				raw_q[e] <= RAW_W'(plc_pkg::dflt_raw(e));
				mv_q[e]  <= plc_pkg::dflt_mv(e);
			end
		end else if (in_fire && in_cmd == plc_pkg::CMD_WRITE) begin
			for (int e = 0; e < TABLE_POINTS; e++) begin
				if (int'(in_index) == e) begin
					raw_q[e] <= in_raw[RAW_W-1:0];
					mv_q[e]  <= in_mv;
				end
			end
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			rd_idx_q  <= '0;
		end else begin
			// Drop the held beat once the sink takes it, unless a new one replaces it
			if (m_valid_q && m_axis_tready && state_q != S_FINISH) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire && in_cmd == plc_pkg::CMD_CONVERT) begin
						x_q      <= in_sample[RAW_W-1:0];
						n_q      <= n_sat;
						rd_idx_q <= '0;
						if (n_sat < CW'(2)) begin
							res_mv_q <= '0;
							res_st_q <= plc_pkg::ST_UNCAL;
							state_q  <= S_FINISH;
						end else begin
							state_q  <= S_RD_FIRST;
						end
					end
				end

				S_RD_FIRST: begin
					// Clamp at or below the first point, else keep it as the lower end
					x0_q <= rd_raw;
					y0_q <= rd_mv;
					if (!rd_lt_x) begin
						res_mv_q <= rd_mv;
						res_st_q <= plc_pkg::ST_OK;
						state_q  <= S_FINISH;
					end else begin
						rd_idx_q <= last_idx;
						state_q  <= S_RD_LAST;
					end
				end

				S_RD_LAST: begin
					// Clamp at or above the last used point
					if (!x_lt_rd) begin
						res_mv_q <= rd_mv;
						res_st_q <= plc_pkg::ST_OK;
						state_q  <= S_FINISH;
					end else begin
						rd_idx_q <= IW'(1);
						state_q  <= S_SCAN;
					end
				end

				S_SCAN: begin
					// Advance until an entry lies above the sample
					if (x_lt_rd) begin
						x1_q    <= rd_raw;
						y1_q    <= rd_mv;
						state_q <= S_MUL;
					end else if (rd_idx_q == last_idx) begin
						res_mv_q <= '0;
						res_st_q <= plc_pkg::ST_NO_SEG;
						state_q  <= S_FINISH;
					end else begin
						x0_q     <= rd_raw;
						y0_q     <= rd_mv;
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end

				S_MUL: begin
					prod_q <= PW'(dx) * PW'(dy_mag);
					den_q  <= dseg;
					neg_q  <= dy_neg;
					if (dseg == '0) begin
						res_mv_q <= y0_q;
						res_st_q <= plc_pkg::ST_OK;
						state_q  <= S_FINISH;
					end else begin
						state_q  <= S_DIV_START;
					end
				end

				S_DIV_START: begin
					state_q <= S_DIV_WAIT;
				end

				S_DIV_WAIT: begin
					if (div_sts.done) begin
						res_st_q <= plc_pkg::ST_OK;
						if (sum < 0) begin
							res_mv_q <= '0;
						end else if (sum > $signed({2'b00, {MV_W{1'b1}}})) begin
							res_mv_q <= '1;
						end else begin
							res_mv_q <= sum[MV_W-1:0];
						end
						state_q <= S_FINISH;
					end
				end

				S_FINISH: begin
					// Hold until the output register is free
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_mv_q    <= res_mv_q;
						m_st_q    <= res_st_q;
						state_q   <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_mv_q;
	assign m_axis_tuser  = m_st_q;

	// A flagged result carries zero volts
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == plc_pkg::ST_OK || m_axis_tdata == '0))
		else $error("flagged result with nonzero millivolts");

	// A convert beat leaves the block busy on the next cycle
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_cmd == plc_pkg::CMD_CONVERT) |=> !s_axis_tready)
		else $error("ready after accepting a sample");

	// The divider is started only when idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_sts.busy)
		else $error("divider restarted while busy");

	// The scan never reads past the used points
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CW'(rd_idx_q) < n_q))
		else $error("scan index past point count");

	// Waiting on the divider implies it is running or has just finished
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_WAIT) |-> (div_sts.busy || div_sts.done))
		else $error("waiting on an idle divider");

endmodule

>>> tb/sv/piecewise_linear_adc_calibration_tb.sv
module piecewise_linear_adc_calibration_tb;

	localparam int TABLE_POINTS = 8;
	localparam int ADC_BITS     = 12;

	// Settling wait, long enough to cover the longest sample
	localparam int SETTLE_CYCLES   = TABLE_POINTS + 32;
	// Cycles with no beat in or out and no register write before the run is declared hung
	localparam int QUIET_LIMIT     = 2000;
	localparam int RANDOM_ITEMS    = 1650;
	localparam int BACKLOG_HOLD    = 400;
	localparam int MAX_PRINTED     = 40;

	typedef logic [plc_pkg::SAMPLE_W-1:0] sample_t;
	typedef logic [plc_pkg::INDEX_W-1:0]  index_t;
	typedef logic [plc_pkg::MV_W-1:0]     mv_t;
	typedef logic [plc_pkg::COUNT_W-1:0]  count_t;

	typedef struct packed {
		logic [plc_pkg::MV_W-1:0]     mv;
		logic [plc_pkg::STATUS_W-1:0] status;
	} mv_reading_t;

	// Receiver stall patterns
	typedef enum int {
		RX_READY,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [47:0]        s_axis_tdata;  // [11:0] sample, [14:12] point_index,
	                                   // [26:15] point_raw, [42:27] point_millivolts
	logic               s_axis_tuser;  // [0] cmd
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [15:0]        m_axis_tdata;  // [15:0] millivolts
	logic [1:0]         m_axis_tuser;  // [1:0] status
	logic               cfg_wen;
	count_t             cfg_wdata;     // [3:0] point_count

	// Shadow of the calibration state, kept in step with accepted beats
	sample_t raw_points [TABLE_POINTS];
	mv_t     mv_points  [TABLE_POINTS];
	count_t  active_count;

	// Readings still owed by the block, oldest first
	mv_reading_t expected_readings [$];

	int  mismatches;
	int  conversions_sent;
	int  writes_sent;
	int  readings_checked;
	int  count_settings;
	int  burst_left;
	bit  tx_gaps_on;
	bit  rx_steady;
	int  rx_hold_req;

	piecewise_linear_adc_calibration #(
		.TABLE_POINTS(TABLE_POINTS),
		.ADC_BITS    (ADC_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the reading for one sample from the shadow table.
	// The step is taken in 64-bit signed and truncated toward zero, then
	// added to the lower point's voltage and clamped to the 16-bit range.
	function automatic mv_reading_t convert_reading(input sample_t reading);
		mv_reading_t r;
		int          n;
		int          i;
		bit          hit;
		longint      x0;
		longint      x1;
		longint      y0;
		longint      y1;
		longint      v;
		r.mv     = '0;
		r.status = plc_pkg::ST_OK;
		hit      = 1'b0;
		// Counts above the table size use the whole table
		n = (active_count > TABLE_POINTS) ? TABLE_POINTS : int'(active_count);
		if (n < 2) begin
			r.status = plc_pkg::ST_UNCAL;
		end else if (reading <= raw_points[0]) begin
			r.mv = mv_points[0];
		end else if (reading >= raw_points[n-1]) begin
			r.mv = mv_points[n-1];
		end else begin
			for (i = 1; i < n && !hit; i++) begin
				if (reading < raw_points[i]) begin
					hit = 1'b1;
					x0  = longint'(raw_points[i-1]);
					x1  = longint'(raw_points[i]);
					y0  = longint'(mv_points[i-1]);
					y1  = longint'(mv_points[i]);
					if (x1 == x0) begin
						// Flat segment: take the lower point's voltage
						r.mv = mv_points[i-1];
					end else begin
						v = y0 + ((longint'(reading) - x0) * (y1 - y0)) / (x1 - x0);
						if (v < 0)
							r.mv = '0;
						else if (v > 65535)
							r.mv = '1;
						else
							r.mv = v[plc_pkg::MV_W-1:0];
					end
				end
			end
			if (!hit)
				r.status = plc_pkg::ST_NO_SEG;
		end
		return r;
	endfunction

	// Pick a sample that lands often on or right beside a table point
	function automatic sample_t pick_reading();
		int sel;
		int k;
		int v;
		sel = $urandom_range(0, 9);
		k   = $urandom_range(0, TABLE_POINTS - 1);
		if (sel < 4)
			return sample_t'($urandom_range(0, 4095));
		if (sel < 8) begin
			v = int'(raw_points[k]) + $urandom_range(0, 6) - 3;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			return sample_t'(v);
		end
		if (sel == 8)
			return raw_points[k];
		return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("MISMATCH %s: got %0d, expected %0d (reading %0d)",
			         what, got, want, readings_checked);
	endtask

	// Offer one beat and hold it until the block takes it, then update the
	// shadow. Bursts of random length are broken by random gaps when enabled.
	// tvalid stays high on return; whoever pauses the sender lowers it.
	task automatic send_item(input logic cmd, input sample_t reading,
	                         input index_t idx, input sample_t raw,
	                         input mv_t mv);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (tx_gaps_on) begin
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {5'b0, mv, raw, idx, reading};
		do @(posedge clk); while (!s_axis_tready);
		if (cmd == plc_pkg::CMD_WRITE) begin
			raw_points[idx] = raw;
			mv_points[idx]  = mv;
			writes_sent++;
		end else begin
			expected_readings = {expected_readings, convert_reading(reading)};
			conversions_sent++;
		end
	endtask

	task automatic send_convert(input sample_t reading);
		send_item(plc_pkg::CMD_CONVERT, reading, index_t'($urandom_range(0, 7)),
		          sample_t'($urandom_range(0, 4095)), mv_t'($urandom_range(0, 65535)));
	endtask

	task automatic send_point(input index_t idx, input sample_t raw, input mv_t mv);
		send_item(plc_pkg::CMD_WRITE, sample_t'($urandom_range(0, 4095)), idx, raw, mv);
	endtask

	// Drop tvalid, wait for every owed reading, then let a trailing point
	// write or search finish before touching the register
	task automatic wait_for_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_point_count(input count_t count);
		wait_for_idle();
		cfg_wdata <= count;
		cfg_wen   <= 1'b1;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		active_count = count;
		count_settings++;
	endtask

	// Well-formed calibration: every entry written with ascending raw codes
	// (flat steps allowed) and arbitrary voltages, so slopes go both ways
	task automatic write_sorted_table();
		int i;
		int prev;
		prev = $urandom_range(0, 1000);
		for (i = 0; i < TABLE_POINTS; i++) begin
			send_point(index_t'(i), sample_t'(prev), mv_t'($urandom_range(0, 65535)));
			if ($urandom_range(0, 9) != 0)
				prev = prev + $urandom_range(0, (4095 - prev) / (TABLE_POINTS - i));
		end
	endtask

	// Factory table after reset: clamps at both ends, an exact point, a midpoint
	task automatic test_factory_table();
		send_convert(12'd0);
		send_convert(12'd2182);
		send_convert(12'd2289);
		send_convert(12'd2396);
		send_convert(12'd3283);
		send_convert(12'hFFF);
	endtask

	// Too few points flags uncalibrated; counts above the table saturate
	task automatic test_point_count();
		set_point_count(4'd0);
		send_convert(12'd0);
		send_convert(12'hFFF);
		set_point_count(4'd1);
		send_convert(12'd2500);
		set_point_count(4'd15);
		send_convert(12'd2289);
		set_point_count(4'd2);
		send_convert(12'd2300);
		send_convert(12'd3000);
	endtask

	// Full-scale points, a falling segment and a repeated raw code
	task automatic test_point_writes();
		send_point(3'd0, 12'd0, 16'd0);
		send_point(3'd1, 12'hFFF, 16'hFFFF);
		send_convert(12'd1);
		send_convert(12'd2048);
		send_convert(12'd4094);
		set_point_count(4'd3);
		send_point(3'd2, 12'hFFF, 16'd0);
		send_point(3'd1, 12'd2000, 16'hFFFF);
		send_convert(12'd3000);
		send_point(3'd1, 12'd0, 16'd777);
		send_convert(12'd100);
		send_convert(12'd0);
	endtask

	// Hold the receiver off for a long stretch while beats keep coming, so
	// the output register fills and the block stalls its input
	task automatic test_output_backpressure();
		int k;
		set_point_count(4'd8);
		tx_gaps_on  = 1'b0;
		rx_hold_req = BACKLOG_HOLD;
		for (k = 0; k < 16; k++)
			send_convert(pick_reading());
		tx_gaps_on = 1'b1;
		wait_for_idle();
	endtask

	// Phases at different point counts; most start from a well-formed table,
	// then mostly conversions with stray point writes mixed in
	task automatic test_random_traffic();
		int phase_counts [10];
		int phase;
		int k;
		int per_phase;
		phase_counts = '{8, 2, 15, 0, 5, 1, 3, 9, 4, 7};
		per_phase    = RANDOM_ITEMS / 10;
		for (phase = 0; phase < 10; phase++) begin
			set_point_count(count_t'(phase_counts[phase]));
			// Alternate stretches with no idling against ones with gaps and stalls
			tx_gaps_on = (phase % 3 == 1);
			rx_steady  = (phase % 3 == 0);
			if ($urandom_range(0, 9) < 7)
				write_sorted_table();
			for (k = 0; k < per_phase; k++) begin
				if ($urandom_range(0, 99) < 12)
					send_point(index_t'($urandom_range(0, 7)),
					           sample_t'($urandom_range(0, 4095)),
					           mv_t'($urandom_range(0, 65535)));
				else
					send_convert(pick_reading());
			end
		end
		rx_steady  = 1'b0;
		tx_gaps_on = 1'b1;
	endtask

	// Receiver: its own stall pattern, switched to a random mode when the last one
	// runs out, plus a counted hold-off on request
	initial begin : rx_pattern
		int       hold_left;
		int       mode_left;
		int       tick;
		rx_mode_t mode;
		hold_left = 0;
		mode_left = 0;
		tick      = 0;
		mode      = RX_READY;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (rx_hold_req > 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				case (mode)
					RX_READY:    m_axis_tready <= 1'b1;
					RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: m_axis_tready <= (tick % 4 == 0);
					default:     m_axis_tready <= 1'b1;
				endcase
			end
		end
	end

	// Compare each beat out with the oldest owed reading
	always @(posedge clk) begin : check_readings
		mv_reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("reading with none owed, millivolts",
				                longint'(m_axis_tdata), -1);
			end else begin
				want = expected_readings.pop_front();
				if (m_axis_tdata !== want.mv)
					report_mismatch("millivolts", longint'(m_axis_tdata), longint'(want.mv));
				if (m_axis_tuser !== want.status)
					report_mismatch("status", longint'(m_axis_tuser),
					                longint'(want.status));
			end
			readings_checked++;
		end
	end

	// Watchdog: count cycles with no beat in, no beat out and no register write
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen)
				quiet = 0;
			else
				quiet++;
		end
		$display("Timed out after %0d quiet cycles, %0d readings owed",
		         QUIET_LIMIT, expected_readings.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= plc_pkg::CMD_CONVERT;
		cfg_wen       <= 1'b0;
		cfg_wdata     <= '0;
		mismatches       = 0;
		conversions_sent = 0;
		writes_sent      = 0;
		readings_checked = 0;
		count_settings   = 0;
		burst_left       = 0;
		tx_gaps_on       = 1'b1;
		rx_steady        = 1'b0;
		rx_hold_req      = 0;
		// Reset state: factory table, all eight points in use
		raw_points   = '{2182, 2396, 2525, 2625, 2748, 2841, 3055, 3283};
		mv_points    = '{10000, 11000, 11500, 12000, 12500, 13000, 14000, 15000};
		active_count = 4'd8;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_factory_table();
		test_point_count();
		test_point_writes();
		test_output_backpressure();
		test_random_traffic();
		wait_for_idle();

		$display("Checked %0d readings from %0d conversions and %0d point writes",
		         readings_checked, conversions_sent, writes_sent);
		$display("over %0d point_count settings, with a %0d-cycle output hold-off",
		         count_settings, BACKLOG_HOLD);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
